>>> rtl/ptrt_pkg.sv
// ----------------------------------------------------------------------------
// ptrt_pkg : shared types and constants of the periodic task ready timer
// Field widths, register codes and the structs that run down the cell chain.
// ----------------------------------------------------------------------------
package ptrt_pkg;

   localparam int PTRT_MAX_TASKS = 4;
   localparam int TICK_W         = 32;
   localparam int SLOT_CAP       = 4;
   localparam int SLOT_IDX_W     = 2;
   localparam int TASK_COUNT_W   = 3;
   localparam int CSR_IDX_W      = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TASK_COUNT   = 3'd0,
      CSR_PERIOD_SLOT0 = 3'd1,
      CSR_PERIOD_SLOT1 = 3'd2,
      CSR_PERIOD_SLOT2 = 3'd3,
      CSR_PERIOD_SLOT3 = 3'd4
   } csr_reg_type;

   // wavefront of one request as it passes from cell to cell
   typedef struct packed {
      logic                  valid;
      logic                  changed;
      logic [TICK_W-1:0]     delta;
      logic [SLOT_CAP-1:0]   served;
      logic                  newly;
      logic [SLOT_CAP-1:0]   mask;
      logic                  found;
      logic [SLOT_IDX_W-1:0] index;
   } wave_type;

   typedef struct packed {
      logic                  newly;
      logic [SLOT_CAP-1:0]   mask;
      logic                  found;
      logic [SLOT_IDX_W-1:0] index;
   } result_type;

   typedef struct packed {
      logic              we;
      logic [TICK_W-1:0] data;
   } period_wr_type;

endpackage

>>> rtl/ptrt_channels.sv
// ----------------------------------------------------------------------------
// ptrt_channels : valid/ready channels of the periodic task ready timer
// Request, response and register write channels with source and sink views.
// ----------------------------------------------------------------------------
interface ptrt_req_if;
   import ptrt_pkg::*;

   logic              valid;
   logic              ready;
   logic [TICK_W-1:0] now_ticks;
   logic [SLOT_CAP-1:0] served_mask;

   modport source (output valid, output now_ticks, output served_mask, input ready);
   modport sink   (input valid, input now_ticks, input served_mask, output ready);
endinterface

interface ptrt_rsp_if;
   import ptrt_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  newly_ready;
   logic [SLOT_CAP-1:0]   ready_mask;
   logic                  ready_found;
   logic [SLOT_IDX_W-1:0] ready_index;

   modport source (output valid, output newly_ready, output ready_mask,
                   output ready_found, output ready_index, input ready);
   modport sink   (input valid, input newly_ready, input ready_mask,
                   input ready_found, input ready_index, output ready);
endinterface

interface ptrt_csr_if;
   import ptrt_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [TICK_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/ptrt_cell.sv
// ----------------------------------------------------------------------------
// ptrt_cell : one task slot of the timer chain
// Holds the period, elapsed time and ready flag of one slot and updates them
// as the request wavefront passes, then hands the wavefront on.
// ----------------------------------------------------------------------------
module ptrt_cell #(
   parameter int SLOT_INDEX = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [ptrt_pkg::TASK_COUNT_W-1:0]   task_count,
   input  ptrt_pkg::period_wr_type             period_wr,
   input  ptrt_pkg::wave_type                  wave_in,
   output ptrt_pkg::wave_type                  wave_out
);
   import ptrt_pkg::*;

   localparam logic [SLOT_IDX_W-1:0]   SLOT      = SLOT_IDX_W'(SLOT_INDEX);
   localparam logic [TASK_COUNT_W-1:0] SLOT_TASK = TASK_COUNT_W'(SLOT_INDEX);

   logic [TICK_W-1:0] period_ff;
   logic [TICK_W-1:0] elapsed_ff, elapsed_in;
   logic              ready_ff, ready_in;
   wave_type          wave_ff, wave_in_next;

   logic              in_use;
   logic              advance;
   logic              fire;
   logic [TICK_W:0]   sum;
   logic [TICK_W-1:0] sat;

   always_comb begin
      in_use  = task_count > SLOT_TASK;
      sum     = {1'b0, elapsed_ff} + {1'b0, wave_in.delta};
      sat     = sum[TICK_W] ? {TICK_W{1'b1}} : sum[TICK_W-1:0];
      advance = wave_in.valid && wave_in.changed && in_use && (period_ff != '0);
      fire    = advance && (sat >= period_ff);

      elapsed_in = elapsed_ff;
      ready_in   = ready_ff;
      if (wave_in.valid) begin
         // served flag drops before the update
         if (wave_in.served[SLOT]) begin
            ready_in = 1'b0;
         end
         if (advance) begin
            elapsed_in = fire ? '0 : sat;
         end
         if (fire) begin
            ready_in = 1'b1;
         end
      end

      wave_in_next             = wave_in;
      wave_in_next.newly       = wave_in.newly | fire;
      wave_in_next.mask[SLOT]  = ready_in;
      if (in_use && ready_in && !wave_in.found) begin
         wave_in_next.found = 1'b1;
         wave_in_next.index = SLOT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= '0;
         elapsed_ff <= '0;
         ready_ff   <= 1'b0;
      end else begin
         if (period_wr.we) begin
            period_ff <= period_wr.data;
         end
         elapsed_ff <= elapsed_in;
         ready_ff   <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff <= '0;
      end else begin
         wave_ff <= wave_in_next;
      end
   end

   assign wave_out = wave_ff;

endmodule

>>> rtl/ptrt_rsp_stage.sv
// ----------------------------------------------------------------------------
// ptrt_rsp_stage : response register with one skid entry
// Takes the wavefront leaving the chain and presents it as a response.
// ----------------------------------------------------------------------------
module ptrt_rsp_stage (
   input  logic               clock,
   input  logic               reset,
   input  ptrt_pkg::wave_type wave_in,
   output logic               hold_full,
   ptrt_rsp_if.source         rsp_ch
);
   import ptrt_pkg::*;

   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       hold_valid_ff, hold_valid_in;
   result_type hold_ff, hold_in;
   result_type res;
   logic       out_free;

   always_comb begin
      res      = '{newly: wave_in.newly, mask: wave_in.mask,
                   found: wave_in.found, index: wave_in.index};
      out_free = !out_valid_ff || rsp_ch.ready;

      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_in        = out_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;

      if (out_free) begin
         if (hold_valid_ff) begin
            out_in        = hold_ff;
            out_valid_in  = 1'b1;
            hold_valid_in = 1'b0;
         end else if (wave_in.valid) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end
      end else if (wave_in.valid) begin
         // park the result while the response still waits
         hold_in       = res;
         hold_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      hold_ff <= hold_in;
   end

   assign hold_full          = hold_valid_ff;
   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.newly_ready = out_ff.newly;
   assign rsp_ch.ready_mask  = out_ff.mask;
   assign rsp_ch.ready_found = out_ff.found;
   assign rsp_ch.ready_index = out_ff.index;

endmodule

>>> rtl/periodic_task_ready_timer.sv
// ----------------------------------------------------------------------------
// periodic_task_ready_timer : ready-flag timer for periodic task slots
// Each request brings a tick sample and a served mask; the response gives
// the ready flags and the lowest ready slot in use.
// ----------------------------------------------------------------------------
// A request is taken when no earlier request is still in the slot chain and
// the response skid entry is empty. The request is registered once (tick
// difference against the last sample), then visits one slot cell per cycle,
// then lands in the response register, so a new request is taken only after
// the previous one has left the slot chain. Register writes are always taken.
module periodic_task_ready_timer #(
   parameter int MAX_TASKS = ptrt_pkg::PTRT_MAX_TASKS
) (
   input  logic       clock,
   input  logic       reset,
   ptrt_req_if.sink   req_ch,
   ptrt_rsp_if.source rsp_ch,
   ptrt_csr_if.sink   csr_ch
);
   import ptrt_pkg::*;

   logic [TASK_COUNT_W-1:0] task_count_ff;
   logic [TICK_W-1:0]       last_sample_ff, last_sample_in;
   wave_type                entry_ff, entry_in;
   wave_type                wave_chain [MAX_TASKS+1];
   period_wr_type           period_wr  [MAX_TASKS];
   logic                    chain_busy;
   logic                    hold_full;
   logic                    accept;
   logic                    csr_we;

   assign csr_ch.ready = 1'b1;
   assign csr_we       = csr_ch.valid && csr_ch.ready;

   always_comb begin
      chain_busy = 1'b0;
      for (int i = 0; i <= MAX_TASKS; i++) begin
         chain_busy = chain_busy | wave_chain[i].valid;
      end
   end

   assign req_ch.ready = !chain_busy && !hold_full;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      entry_in         = '0;
      entry_in.valid   = accept;
      entry_in.changed = req_ch.now_ticks != last_sample_ff;
      entry_in.delta   = req_ch.now_ticks - last_sample_ff;
      entry_in.served  = req_ch.served_mask;
      last_sample_in   = accept ? req_ch.now_ticks : last_sample_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff  <= '0;
         last_sample_ff <= '0;
      end else begin
         last_sample_ff <= last_sample_in;
         if (csr_we) begin
            unique case (csr_ch.index)
               CSR_TASK_COUNT: task_count_ff <= csr_ch.data[TASK_COUNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign wave_chain[0] = entry_ff;

   for (genvar g = 0; g < MAX_TASKS; g++) begin : g_slot
      assign period_wr[g].we   = csr_we &&
         (csr_ch.index == (CSR_IDX_W'(CSR_PERIOD_SLOT0) + CSR_IDX_W'(g)));
      assign period_wr[g].data = csr_ch.data;

      ptrt_cell #(
         .SLOT_INDEX (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .task_count (task_count_ff),
         .period_wr  (period_wr[g]),
         .wave_in    (wave_chain[g]),
         .wave_out   (wave_chain[g+1])
      );
   end

   ptrt_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .wave_in   (wave_chain[MAX_TASKS]),
      .hold_full (hold_full),
      .rsp_ch    (rsp_ch)
   );

endmodule
